@@ design/first_fit_heap_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines.svh
// Assertion macros used by the allocator's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_SAME(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);

`endif

@@ design/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Sizes, header layout and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	localparam int HEAP_BYTES = 4096;
	localparam int HDR_BYTES  = 8;

	localparam int ADDR_W  = $clog2(HEAP_BYTES);
	localparam int COUNT_W = 13;
	localparam int SIZE_W  = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;
	localparam int OFF_W   = SIZE_W + 1;
	localparam int DATA_W  = 32;

	// One block header: valid, occupied and payload size in bytes.
	typedef struct packed {
		logic              valid;
		logic              occ;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_NOFIT = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_NOTOCC = 2'd3;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_ALLOC    = 2'd0;
	localparam mode_t MODE_FREE     = 2'd1;
	localparam mode_t MODE_COALESCE = 2'd2;
	localparam mode_t MODE_NOP      = 2'd3;

endpackage

`default_nettype wire

@@ design/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a header store held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Signals                           Handshake
// request    in         mode, byte_count, address         start & !busy
// result     out        result_address, status            done (one cycle)
// config     in         cfg_wdata                         cfg_we
//
// After reset a clearing pass writes every one of the HEAP_BYTES (4096)
// header entries, one per cycle; busy is high during it and configuration
// writes are still taken. A free checks the pointer, then reads its header
// and marks it free; a zero-size allocate or an ignored mode is answered
// straight from idle. Allocate and coalesce read the block headers in turn;
// coalesce reads on past a free block through the free blocks after it and
// writes back the merged header. Each header visit waits on the registered
// read data of the header RAM. The result beat cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ffha_pkg::DATA_W-1:0]   cfg_wdata,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    mode,
	input  wire logic [ffha_pkg::COUNT_W-1:0]  byte_count,
	input  wire logic [ffha_pkg::DATA_W-1:0]   address,
	output logic                               done,
	output logic [ffha_pkg::DATA_W-1:0]        result_address,
	output logic [1:0]                         status
);

	localparam int AW = ffha_pkg::ADDR_W;
	localparam int SW = ffha_pkg::SIZE_W;
	localparam int OW = ffha_pkg::OFF_W;
	localparam int DW = ffha_pkg::DATA_W;

	localparam logic [OW-1:0] HDR_OFF  = OW'(ffha_pkg::HDR_BYTES);
	localparam logic [OW-1:0] HEAP_OFF = OW'(ffha_pkg::HEAP_BYTES);
	localparam logic [SW-1:0] HDR_SZ   = SW'(ffha_pkg::HDR_BYTES);
	localparam logic [DW:0]   HEAP_33  = (DW+1)'(ffha_pkg::HEAP_BYTES);
	localparam logic [DW-1:0] HDR_32   = DW'(ffha_pkg::HDR_BYTES);
	localparam logic [DW-1:0] HEAP_32  = DW'(ffha_pkg::HEAP_BYTES);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_RD, S_A_EVAL, S_A_SPLIT, S_F_CHK, S_F_EVAL,
		S_C_RD, S_C_EVAL, S_C_NRD, S_C_NEVAL, S_C_WB
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [DW-1:0]        heap_base_q;
	logic [SW-1:0]        count_q;
	logic [DW-1:0]        addr_q;
	logic [OW-1:0]        off_q;
	logic [OW-1:0]        next_q;
	logic [SW-1:0]        size_q;
	logic [OW-1:0]        nb_q;
	logic [AW-1:0]        foff_q;
	logic                 done_q;
	logic [DW-1:0]        result_q;
	ffha_pkg::status_t    status_q;

	// Header RAM ports.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	ffha_pkg::hdr_t       ram_wdata;
	logic [AW-1:0]        ram_raddr;
	ffha_pkg::hdr_t       rd;

	// Derived values.
	logic                 fit;
	logic [SW-1:0]        spare;
	logic [OW-1:0]        nb;
	logic [OW-1:0]        hop;
	logic [SW-1:0]        merged;
	logic [DW:0]          lim;
	logic                 out_of_range;
	logic [DW-1:0]        rel;
	logic [DW-1:0]        rel_off;

	ffha_hdr_ram #(
		.DEPTH (ffha_pkg::HEAP_BYTES),
		.WIDTH (ffha_pkg::HDR_W)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	// Header arithmetic on the word just read from the RAM.
	assign fit    = rd.valid && !rd.occ && (rd.size >= count_q);
	assign spare  = rd.size - count_q;
	assign nb     = off_q + HDR_OFF + OW'(count_q);
	assign hop    = off_q + HDR_OFF + OW'(rd.size);
	assign merged = size_q + HDR_SZ + rd.size;

	// Pointer check for free: a pointer equal to the heap limit still passes.
	assign lim          = {1'b0, heap_base_q} + HEAP_33;
	assign out_of_range = (addr_q == '0) || (addr_q < heap_base_q) ||
		({1'b0, addr_q} > lim);
	assign rel          = addr_q - heap_base_q;
	assign rel_off      = rel - HDR_32;

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign result_address = result_q;
	assign status         = status_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = off_q[AW-1:0];
		ram_wdata = '0;
		ram_raddr = off_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				// Every entry starts invalid except one free block at offset zero.
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == '0) begin
					ram_wdata = '{valid: 1'b1, occ: 1'b0,
						size: SW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HDR_BYTES)};
				end
			end
			S_A_EVAL: begin
				if (fit) begin
					ram_we    = 1'b1;
					ram_wdata = '{valid: 1'b1, occ: 1'b1,
						size: (spare >= HDR_SZ) ? count_q : rd.size};
				end
			end
			S_A_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = nb_q[AW-1:0];
				ram_wdata = '{valid: 1'b1, occ: 1'b0, size: size_q};
			end
			S_F_CHK: begin
				ram_raddr = rel_off[AW-1:0];
			end
			S_F_EVAL: begin
				if (rd.valid && rd.occ) begin
					ram_we    = 1'b1;
					ram_waddr = foff_q;
					ram_wdata = '{valid: 1'b1, occ: 1'b0, size: rd.size};
				end
			end
			S_C_NRD: begin
				ram_raddr = next_q[AW-1:0];
			end
			S_C_NEVAL: begin
				// An absorbed header becomes invalid.
				if (rd.valid && !rd.occ) begin
					ram_we    = 1'b1;
					ram_waddr = next_q[AW-1:0];
				end
			end
			S_C_WB: begin
				ram_we    = 1'b1;
				ram_wdata = '{valid: 1'b1, occ: 1'b0, size: size_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			heap_base_q <= '0;
			count_q     <= '0;
			addr_q      <= '0;
			off_q       <= '0;
			next_q      <= '0;
			size_q      <= '0;
			nb_q        <= '0;
			foff_q      <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
			status_q    <= ffha_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				heap_base_q <= cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						count_q  <= SW'(byte_count);
						addr_q   <= address;
						off_q    <= '0;
						result_q <= '0;
						status_q <= ffha_pkg::ST_OK;
						case (mode)
							ffha_pkg::MODE_ALLOC: begin
								if (byte_count == '0) begin
									status_q <= ffha_pkg::ST_NOFIT;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_A_RD;
								end
							end
							ffha_pkg::MODE_FREE: begin
								state_q <= S_F_CHK;
							end
							ffha_pkg::MODE_COALESCE: begin
								state_q <= S_C_RD;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_A_RD: begin
					if (off_q >= HEAP_OFF) begin
						status_q <= ffha_pkg::ST_NOFIT;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_A_EVAL;
					end
				end
				S_A_EVAL: begin
					if (!rd.valid) begin
						status_q <= ffha_pkg::ST_NOFIT;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (fit) begin
						result_q <= heap_base_q + DW'(off_q) + HDR_32;
						size_q   <= spare - HDR_SZ;
						nb_q     <= nb;
						if ((spare >= HDR_SZ) && (nb < HEAP_OFF)) begin
							state_q <= S_A_SPLIT;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						off_q   <= hop;
						state_q <= S_A_RD;
					end
				end
				S_A_SPLIT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F_CHK: begin
					foff_q <= rel_off[AW-1:0];
					if (out_of_range) begin
						status_q <= ffha_pkg::ST_RANGE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if ((rel < HDR_32) || (rel_off >= HEAP_32)) begin
						status_q <= ffha_pkg::ST_NOTOCC;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_F_EVAL;
					end
				end
				S_F_EVAL: begin
					if (!(rd.valid && rd.occ)) begin
						status_q <= ffha_pkg::ST_NOTOCC;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_C_RD: begin
					if (off_q >= HEAP_OFF) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_C_EVAL;
					end
				end
				S_C_EVAL: begin
					if (!rd.valid) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (rd.occ) begin
						off_q   <= hop;
						state_q <= S_C_RD;
					end else begin
						size_q  <= rd.size;
						next_q  <= hop;
						state_q <= S_C_NRD;
					end
				end
				S_C_NRD: begin
					if (next_q >= HEAP_OFF) begin
						state_q <= S_C_WB;
					end else begin
						state_q <= S_C_NEVAL;
					end
				end
				S_C_NEVAL: begin
					if (rd.valid && !rd.occ) begin
						size_q  <= merged;
						next_q  <= off_q + HDR_OFF + OW'(merged);
						state_q <= S_C_NRD;
					end else begin
						state_q <= S_C_WB;
					end
				end
				S_C_WB: begin
					off_q   <= next_q;
					state_q <= S_C_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result beat always lands as the engine returns to idle.
	`FFHA_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "result beat while busy")
	// An accepted request either occupies the engine or is answered at once.
	`FFHA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy || done, "accept lost")
	// Only a successful allocation carries a nonzero address.
	`FFHA_ASSERT_SAME(a_addr_ok, clk, arst_n, done && (result_address != '0),
		status == ffha_pkg::ST_OK, "address returned with error status")

endmodule

`default_nettype wire

@@ design/ffha_hdr_ram.sv @@
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 15
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
